FILE: rtl/arpr_pkg.sv
// Shared types, constants and reply microcode for the ARP reply responder.
package arpr_pkg;

    localparam logic [15:0] ARP_TYPE  = 16'h0806;
    localparam logic [15:0] IP_TYPE   = 16'h0800;
    localparam int          REPLY_LEN = 14 + 28;
    localparam logic [5:0]  POS_MAX   = 6'd63;
    localparam logic [5:0]  POS_LAST  = 6'(REPLY_LEN - 1);
    localparam logic [47:0] LOCAL_MAC_RESET = 48'h020304050607;

    localparam logic REG_LOCAL_MAC = 1'b0;
    localparam logic REG_LOCAL_IP  = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef enum logic [2:0]
    {
        SRC_CONST,
        SRC_PEER,
        SRC_LMAC,
        SRC_AIP,
        SRC_RMAC,
        SRC_RIP
    } src_t;

    typedef struct packed
    {
        src_t       src;
        logic [2:0] idx;
        logic [7:0] data;
        logic       fin;
    } uword_t;

    function automatic uword_t ucode(input logic [5:0] step);
        uword_t w;
        w.src  = SRC_CONST;
        w.idx  = 3'd0;
        w.data = 8'h00;
        w.fin  = 1'b0;
        priority if (step <= 6'd5)
        begin
            w.src = SRC_PEER;
            w.idx = 3'(6'd5 - step);
        end
        else if (step <= 6'd11)
        begin
            w.src = SRC_LMAC;
            w.idx = 3'(6'd11 - step);
        end
        else if (step <= 6'd21)
        begin
            unique case (step)
                6'd12:   w.data = ARP_TYPE[15:8];
                6'd13:   w.data = ARP_TYPE[7:0];
                6'd14:   w.data = 8'h00;
                6'd15:   w.data = 8'h01;
                6'd16:   w.data = IP_TYPE[15:8];
                6'd17:   w.data = IP_TYPE[7:0];
                6'd18:   w.data = 8'h06;
                6'd19:   w.data = 8'h04;
                6'd20:   w.data = 8'h00;
                default: w.data = 8'h02;
            endcase
        end
        else if (step <= 6'd27)
        begin
            w.src = SRC_LMAC;
            w.idx = 3'(6'd27 - step);
        end
        else if (step <= 6'd31)
        begin
            w.src = SRC_AIP;
            w.idx = 3'(6'd31 - step);
        end
        else if (step <= 6'd37)
        begin
            w.src = SRC_RMAC;
            w.idx = 3'(6'd37 - step);
        end
        else if (step <= 6'd40)
        begin
            w.src = SRC_RIP;
            w.idx = 3'(6'd41 - step);
        end
        else
        begin
            w.src = SRC_RIP;
            w.idx = 3'd0;
            w.fin = 1'b1;
        end
        return w;
    endfunction

endpackage

FILE: rtl/arp_reply_responder.sv
// ARP reply responder: frame capture, match check and microcoded reply sequencer.
//
// Usage: a received Ethernet frame enters on rx_byte/rx_last, one word per
// accepted cycle, starting at the destination MAC; rx_last marks its final word.
// When that final word completes a frame of at least 42 words with EtherType
// 0x0806 and an ARP target IP equal to local_ip, a 42-word ARP reply leaves
// on tx_byte/tx_last, tx_last high on its final word.
// Receive runs at one word per cycle while rx_ready is high. The reply is stepped
// out by a 42-step microcode program, one control word per cycle unless tx_ready
// stalls; the first reply word is loaded into the output register once the
// sequencer is in its send state after the final receive word is accepted.
// While the program runs rx_ready is low; it returns once the last reply word is
// loaded into the output register. A stall on tx_ready holds the output register
// and the step counter. Reset: step counter idle, byte position zero, captured
// fields zero, local_mac 02:03:04:05:06:07, local_ip 0. Configuration over APB
// at byte address 0 (local_mac) and 8 (local_ip); the user must see they are
// written only while idle, as the block itself does not enforce this.
module arp_reply_responder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    input  logic        rx_last,
    output logic        tx_valid,
    input  logic        tx_ready,
    output logic [7:0]  tx_byte,
    output logic        tx_last
);

    logic [47:0] local_mac_reg;
    logic [31:0] local_ip_reg;
    logic [5:0]  pos_reg;
    logic [47:0] peer_mac_reg;
    logic [15:0] frame_type_reg;
    logic [47:0] req_mac_reg;
    logic [31:0] req_ip_reg;
    logic [31:0] asked_ip_reg;
    logic [31:0] asked_ip_next;

    arpr_pkg::state_t state_reg;
    arpr_pkg::state_t state_next;
    logic [5:0]       step_reg;
    logic [5:0]       step_next;
    logic             load;

    logic             tx_valid_reg;
    logic [7:0]       tx_byte_reg;
    logic             tx_last_reg;

    arpr_pkg::uword_t uw;
    logic [47:0]      src_val;
    logic [7:0]       sel_byte;
    logic             rx_fire;
    logic             cfg_wr;
    logic             match;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[3] == arpr_pkg::REG_LOCAL_IP) ? {32'h0, local_ip_reg}
                                                           : {16'h0, local_mac_reg};
    assign rx_ready = (state_reg == arpr_pkg::ST_IDLE);
    assign rx_fire  = rx_valid && rx_ready;
    assign tx_valid = tx_valid_reg;
    assign tx_byte  = tx_byte_reg;
    assign tx_last  = tx_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac_reg <= arpr_pkg::LOCAL_MAC_RESET;
            local_ip_reg  <= 32'h0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == arpr_pkg::REG_LOCAL_MAC)
                local_mac_reg <= pwdata[47:0];
            else
                local_ip_reg <= pwdata[31:0];
        end
    end

    assign asked_ip_next = (pos_reg >= 6'd38 && pos_reg <= 6'd41)
                           ? {asked_ip_reg[23:0], rx_byte} : asked_ip_reg;
    assign match = rx_last && (pos_reg >= arpr_pkg::POS_LAST)
                   && (frame_type_reg == arpr_pkg::ARP_TYPE)
                   && (asked_ip_next == local_ip_reg);

    // capture frame fields by byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 6'd0;
            peer_mac_reg   <= 48'h0;
            frame_type_reg <= 16'h0;
            req_mac_reg    <= 48'h0;
            req_ip_reg     <= 32'h0;
            asked_ip_reg   <= 32'h0;
        end
        else if (rx_fire)
        begin
            if (pos_reg >= 6'd6 && pos_reg <= 6'd11)
                peer_mac_reg <= {peer_mac_reg[39:0], rx_byte};
            if (pos_reg >= 6'd12 && pos_reg <= 6'd13)
                frame_type_reg <= {frame_type_reg[7:0], rx_byte};
            if (pos_reg >= 6'd22 && pos_reg <= 6'd27)
                req_mac_reg <= {req_mac_reg[39:0], rx_byte};
            if (pos_reg >= 6'd28 && pos_reg <= 6'd31)
                req_ip_reg <= {req_ip_reg[23:0], rx_byte};
            asked_ip_reg <= asked_ip_next;
            if (rx_last)
                pos_reg <= 6'd0;
            else if (pos_reg != arpr_pkg::POS_MAX)
                pos_reg <= pos_reg + 6'd1;
        end
    end

    assign uw = arpr_pkg::ucode(step_reg);

    always_comb
    begin
        unique case (uw.src)
            arpr_pkg::SRC_PEER: src_val = peer_mac_reg;
            arpr_pkg::SRC_LMAC: src_val = local_mac_reg;
            arpr_pkg::SRC_AIP:  src_val = {16'h0, asked_ip_reg};
            arpr_pkg::SRC_RMAC: src_val = req_mac_reg;
            arpr_pkg::SRC_RIP:  src_val = {16'h0, req_ip_reg};
            default:            src_val = {40'h0, uw.data};
        endcase
        unique case (uw.idx)
            3'd1:    sel_byte = src_val[15:8];
            3'd2:    sel_byte = src_val[23:16];
            3'd3:    sel_byte = src_val[31:24];
            3'd4:    sel_byte = src_val[39:32];
            3'd5:    sel_byte = src_val[47:40];
            default: sel_byte = src_val[7:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        load       = 1'b0;
        unique case (state_reg)
            arpr_pkg::ST_IDLE:
            begin
                if (rx_fire && match)
                begin
                    state_next = arpr_pkg::ST_SEND;
                    step_next  = 6'd0;
                end
            end
            default:
            begin
                if (!tx_valid_reg || tx_ready)
                begin
                    load = 1'b1;
                    if (uw.fin)
                    begin
                        state_next = arpr_pkg::ST_IDLE;
                        step_next  = 6'd0;
                    end
                    else
                        step_next = step_reg + 6'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= arpr_pkg::ST_IDLE;
            step_reg     <= 6'd0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (load)
                tx_valid_reg <= 1'b1;
            else if (tx_ready)
                tx_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg <= sel_byte;
            tx_last_reg <= uw.fin;
        end
    end

endmodule

FILE: rtl/arpr_checker.sv
// Port-level checker for the ARP reply responder, bound to the top level.
module arpr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       rx_ready,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic [7:0] tx_byte,
    input logic       tx_last
);

    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(tx_last))
        else $error("tx word changed while stalled");

    a_reply_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_ready && !tx_last |=> tx_valid)
        else $error("gap inside reply");

    a_rx_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_last |-> !rx_ready)
        else $error("receive open during reply");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind arp_reply_responder arpr_checker u_arpr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .rx_ready (rx_ready),
    .tx_valid (tx_valid),
    .tx_ready (tx_ready),
    .tx_byte  (tx_byte),
    .tx_last  (tx_last)
);
